### hdl/goal_command_retry_lane_core_assert.svh
// ----------------------------------------------------------------------------
// Goal command retry lane: assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GOAL_COMMAND_RETRY_LANE_CORE_ASSERT_SVH
`define GOAL_COMMAND_RETRY_LANE_CORE_ASSERT_SVH

`ifndef SYNTH
// Assert a property on the rising clock edge, disabled during reset.
`define GCRL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("goal_command_retry_lane_core: assertion failed");
// Assert a property on the rising clock edge, also checked in reset.
`define GCRL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("goal_command_retry_lane_core: assertion failed");
`else
`define GCRL_ASSERT(lbl, clk, rstn, prop)
`define GCRL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### hdl/gcrl_pkg.sv
// ----------------------------------------------------------------------------
// Goal command retry lane: package
// Event codes, status codes, deadline codes, command kinds and configuration.
// ----------------------------------------------------------------------------
package gcrl_pkg;

  // Event carried by one input transaction
  typedef enum logic [2:0] {
    FUNC_BEGIN    = 3'd0,
    FUNC_CANCEL   = 3'd1,
    FUNC_TICK     = 3'd2,
    FUNC_ACK      = 3'd3,
    FUNC_WRESULT  = 3'd4,
    FUNC_DEADLINE = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY_ID  = 2'd1,
    STATUS_NO_GOAL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    DL_NONE        = 2'd0,
    DL_START_ACK   = 2'd1,
    DL_CANCEL_TERM = 2'd2
  } deadline_e;

  // Command kind of an emitted write or an acknowledgement
  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_CANCEL = 1'b1;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_INTERVAL  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COMMAND_TIMEOUT = 2'd1;

  localparam logic [31:0] RETRY_INTERVAL_RST  = 32'd100;
  localparam logic [31:0] COMMAND_TIMEOUT_RST = 32'd1000;

endpackage

### hdl/goal_command_retry_lane_core.sv
// ----------------------------------------------------------------------------
// Goal command retry lane core
// Binds one goal, resends its start or cancel command on ticks until it is
// acknowledged, and latches a deadline code when a phase times out.
// ----------------------------------------------------------------------------
// One event is accepted per clock cycle and its result appears in the output
// register on the next cycle; the input is ready whenever the output register
// is empty or being drained in the same cycle, so the lane sustains one
// transaction per cycle while out_ready_i keeps up. The cycle is set by the
// wrapping 32-bit time subtraction and compare against the retry interval and
// the command timeout. goal_active_o and cancel_pending_o show the goal state
// after the event whose result is on the output. Configuration is written
// through a plain write port and must only change while the lane is idle.
module goal_command_retry_lane_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [gcrl_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   func_i,
  input  logic [31:0]                  now_time_i,
  input  logic [15:0]                  task_id_i,
  input  logic [15:0]                  req_id_i,
  input  logic                         id_is_cancel_i,
  input  logic                         ack_kind_i,
  input  logic                         ack_accepted_i,
  input  logic                         write_ok_i,
  input  logic [31:0]                  target_i,
  input  logic [7:0]                   reason_code_i,
  input  logic                         link_ready_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic                         write_valid_o,
  output logic                         write_kind_o,
  output logic [15:0]                  write_task_id_o,
  output logic [15:0]                  write_req_id_o,
  output logic [31:0]                  write_target_o,
  output logic [7:0]                   write_reason_o,
  output logic                         cancel_accepted_o,
  output logic [1:0]                   deadline_code_o,
  output logic                         goal_active_o,
  output logic                         cancel_pending_o
);
  import gcrl_pkg::*;

  // Configuration registers
  logic [31:0] retry_q, timeout_q;

  // Goal state
  logic        active_q, active_d;
  logic [15:0] bound_task_q, bound_task_d;
  logic [15:0] bound_request_q, bound_request_d;
  logic [31:0] bound_target_q, bound_target_d;
  logic        in_cancel_q, in_cancel_d;
  logic [7:0]  saved_reason_q, saved_reason_d;
  logic        start_sent_valid_q, start_sent_valid_d;
  logic [31:0] start_sent_time_q, start_sent_time_d;
  logic        cancel_sent_valid_q, cancel_sent_valid_d;
  logic [31:0] cancel_sent_time_q, cancel_sent_time_d;
  logic [31:0] phase_start_q, phase_start_d;
  deadline_e   pending_code_q, pending_code_d;
  logic        start_done_q, start_done_d;
  logic        start_acked_q, start_acked_d;
  logic        cancel_done_ack_q, cancel_done_ack_d;
  logic        expired_q, expired_d;

  // Result register
  logic        out_valid_q;
  status_e     status_q, status_d;
  logic        wvalid_q, wvalid_d;
  logic        wkind_q, wkind_d;
  logic [15:0] wtask_q, wtask_d;
  logic [15:0] wreq_q, wreq_d;
  logic [31:0] wtarget_q, wtarget_d;
  logic [7:0]  wreason_q, wreason_d;
  logic        caccept_q, caccept_d;
  deadline_e   dcode_q, dcode_d;

  logic        in_fire;
  logic        due, start_retry_due, cancel_retry_due, cancel_match;
  logic [31:0] since_phase, since_start, since_cancel;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Wrapping elapsed-time compares
  assign since_phase      = now_time_i - phase_start_q;
  assign since_start      = now_time_i - start_sent_time_q;
  assign since_cancel     = now_time_i - cancel_sent_time_q;
  assign due              = since_phase >= timeout_q;
  assign start_retry_due  = !start_sent_valid_q || (since_start >= retry_q);
  assign cancel_retry_due = !cancel_sent_valid_q || (since_cancel >= retry_q);
  assign cancel_match     = in_cancel_q ? (id_is_cancel_i && req_id_i == bound_request_q)
                                        : (!id_is_cancel_i && req_id_i == 16'd0);

  // Compute next goal state and the result of one event
  always_comb begin
    active_d            = active_q;
    bound_task_d        = bound_task_q;
    bound_request_d     = bound_request_q;
    bound_target_d      = bound_target_q;
    in_cancel_d         = in_cancel_q;
    saved_reason_d      = saved_reason_q;
    start_sent_valid_d  = start_sent_valid_q;
    start_sent_time_d   = start_sent_time_q;
    cancel_sent_valid_d = cancel_sent_valid_q;
    cancel_sent_time_d  = cancel_sent_time_q;
    phase_start_d       = phase_start_q;
    pending_code_d      = pending_code_q;
    start_done_d        = start_done_q;
    start_acked_d       = start_acked_q;
    cancel_done_ack_d   = cancel_done_ack_q;
    expired_d           = expired_q;

    status_d  = STATUS_OK;
    wvalid_d  = 1'b0;
    wkind_d   = KIND_START;
    wtask_d   = '0;
    wreq_d    = '0;
    wtarget_d = '0;
    wreason_d = '0;
    caccept_d = 1'b0;
    dcode_d   = DL_NONE;

    case (func_i)
      FUNC_BEGIN: begin
        if (task_id_i == 16'd0 || req_id_i == 16'd0) begin
          status_d = STATUS_EMPTY_ID;
        end else begin
          // Replace any bound goal
          active_d            = 1'b1;
          bound_task_d        = task_id_i;
          bound_request_d     = req_id_i;
          bound_target_d      = target_i;
          in_cancel_d         = 1'b0;
          saved_reason_d      = '0;
          start_sent_valid_d  = 1'b0;
          start_sent_time_d   = '0;
          cancel_sent_valid_d = 1'b0;
          cancel_sent_time_d  = '0;
          phase_start_d       = now_time_i;
          pending_code_d      = DL_NONE;
          start_done_d        = 1'b0;
          start_acked_d       = 1'b0;
          cancel_done_ack_d   = 1'b0;
          expired_d           = 1'b0;
        end
      end
      FUNC_CANCEL: begin
        if (!active_q) begin
          status_d = STATUS_NO_GOAL;
        end else if (in_cancel_q) begin
          caccept_d = 1'b1;
        end else if (!start_done_q) begin
          // Drop the goal: nothing was written yet
          active_d            = 1'b0;
          bound_task_d        = '0;
          bound_request_d     = '0;
          bound_target_d      = '0;
          saved_reason_d      = '0;
          start_sent_valid_d  = 1'b0;
          start_sent_time_d   = '0;
          cancel_sent_valid_d = 1'b0;
          cancel_sent_time_d  = '0;
          phase_start_d       = '0;
          pending_code_d      = DL_NONE;
          start_acked_d       = 1'b0;
          cancel_done_ack_d   = 1'b0;
          expired_d           = 1'b0;
        end else begin
          in_cancel_d    = 1'b1;
          saved_reason_d = reason_code_i;
          phase_start_d  = now_time_i;
          pending_code_d = DL_NONE;
          expired_d      = 1'b0;
          caccept_d      = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (active_q) begin
          if (!expired_q && due && (in_cancel_q || !start_acked_q)) begin
            expired_d      = 1'b1;
            pending_code_d = in_cancel_q ? DL_CANCEL_TERM : DL_START_ACK;
          end else if (!expired_q && link_ready_i) begin
            // Send or resend the command of the current phase
            if (!in_cancel_q) begin
              if (!start_acked_q && start_retry_due) begin
                wvalid_d           = 1'b1;
                wkind_d            = KIND_START;
                wtask_d            = bound_task_q;
                wreq_d             = bound_request_q;
                wtarget_d          = bound_target_q;
                start_sent_valid_d = 1'b1;
                start_sent_time_d  = now_time_i;
              end
            end else if (!cancel_done_ack_q && cancel_retry_due) begin
              wvalid_d            = 1'b1;
              wkind_d             = KIND_CANCEL;
              wtask_d             = bound_task_q;
              wreq_d              = bound_request_q;
              wreason_d           = saved_reason_q;
              cancel_sent_valid_d = 1'b1;
              cancel_sent_time_d  = now_time_i;
            end
          end
        end
      end
      FUNC_ACK: begin
        if (active_q && task_id_i == bound_task_q) begin
          if (ack_kind_i == KIND_START) begin
            if (!id_is_cancel_i && req_id_i == bound_request_q) begin
              start_acked_d = 1'b1;
            end
          end else if (cancel_match) begin
            cancel_done_ack_d = ack_accepted_i;
          end
        end
      end
      FUNC_WRESULT: begin
        if (active_q && req_id_i == bound_request_q) begin
          if (!id_is_cancel_i) begin
            if (write_ok_i) begin
              start_done_d = 1'b1;
            end else begin
              start_sent_valid_d = 1'b0;
            end
          end else if (in_cancel_q && !write_ok_i) begin
            cancel_sent_valid_d = 1'b0;
          end
        end
      end
      FUNC_DEADLINE: begin
        dcode_d        = pending_code_q;
        pending_code_d = DL_NONE;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q   <= RETRY_INTERVAL_RST;
      timeout_q <= COMMAND_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RETRY_INTERVAL:  retry_q   <= cfg_data_i;
        CFG_COMMAND_TIMEOUT: timeout_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Advance goal state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q            <= 1'b0;
      bound_task_q        <= '0;
      bound_request_q     <= '0;
      bound_target_q      <= '0;
      in_cancel_q         <= 1'b0;
      saved_reason_q      <= '0;
      start_sent_valid_q  <= 1'b0;
      start_sent_time_q   <= '0;
      cancel_sent_valid_q <= 1'b0;
      cancel_sent_time_q  <= '0;
      phase_start_q       <= '0;
      pending_code_q      <= DL_NONE;
      start_done_q        <= 1'b0;
      start_acked_q       <= 1'b0;
      cancel_done_ack_q   <= 1'b0;
      expired_q           <= 1'b0;
    end else if (in_fire) begin
      active_q            <= active_d;
      bound_task_q        <= bound_task_d;
      bound_request_q     <= bound_request_d;
      bound_target_q      <= bound_target_d;
      in_cancel_q         <= in_cancel_d;
      saved_reason_q      <= saved_reason_d;
      start_sent_valid_q  <= start_sent_valid_d;
      start_sent_time_q   <= start_sent_time_d;
      cancel_sent_valid_q <= cancel_sent_valid_d;
      cancel_sent_time_q  <= cancel_sent_time_d;
      phase_start_q       <= phase_start_d;
      pending_code_q      <= pending_code_d;
      start_done_q        <= start_done_d;
      start_acked_q       <= start_acked_d;
      cancel_done_ack_q   <= cancel_done_ack_d;
      expired_q           <= expired_d;
    end
  end

  // Hold the result until the output transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q  <= status_d;
      wvalid_q  <= wvalid_d;
      wkind_q   <= wkind_d;
      wtask_q   <= wtask_d;
      wreq_q    <= wreq_d;
      wtarget_q <= wtarget_d;
      wreason_q <= wreason_d;
      caccept_q <= caccept_d;
      dcode_q   <= dcode_d;
    end
  end

  // Goal state only moves when the output register reloads
  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign write_valid_o      = wvalid_q;
  assign write_kind_o       = wkind_q;
  assign write_task_id_o    = wtask_q;
  assign write_req_id_o     = wreq_q;
  assign write_target_o     = wtarget_q;
  assign write_reason_o     = wreason_q;
  assign cancel_accepted_o  = caccept_q;
  assign deadline_code_o    = dcode_q;
  assign goal_active_o      = active_q;
  assign cancel_pending_o   = in_cancel_q;

  `include "goal_command_retry_lane_core_assert.svh"

  `GCRL_ASSERT(a_cancel_needs_goal, clk_i, rst_ni, in_cancel_q |-> active_q)
  `GCRL_ASSERT(a_pending_needs_goal, clk_i, rst_ni, (pending_code_q != DL_NONE) |-> active_q)
  `GCRL_ASSERT(a_cancel_after_start, clk_i, rst_ni, $rose(in_cancel_q) |-> start_done_q)
  `GCRL_ASSERT(a_write_needs_goal, clk_i, rst_ni, (out_valid_q && wvalid_q) |-> active_q)

endmodule
